[hw/rtl/impe_pkg.sv]
`timescale 1ns / 1ps
package impe_pkg;

	localparam int                 DATA_W    = 32;
	localparam int                 ENTRY_W   = 53;
	localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;
	// floor(n / 1000) == (n * DIV_MAGIC) >> DIV_SHIFT for every 32-bit n
	localparam logic signed [32:0] DIV_MAGIC = 33'sd274877907;
	localparam int                 DIV_SHIFT = 38;
	localparam logic [31:0]        HALF_MM   = 32'd500;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_XDIV,
		S_XFIX,
		S_YDIV,
		S_YFIX,
		S_RD,
		S_TERM,
		S_POW,
		S_POWFIX,
		S_ACC,
		S_DONE
	} state_t;

	// round(p / 2^16), ties away from zero
	function automatic logic signed [63:0] rnd_q16(input logic signed [65:0] p);
		logic [65:0] m;
		logic [65:0] r;
		m = p[65] ? 66'(-p) : 66'(p);
		r = (m + 66'h8000) >> 16;
		return p[65] ? 64'(-r) : 64'(r);
	endfunction

	function automatic logic sat_hit(input logic signed [63:0] v);
		return (v > 64'sd2147483647) || (v < -64'sd2147483648);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[hw/rtl/impe_ram.sv]
`timescale 1ns / 1ps
module impe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/inverse_map_polynomial_eval_core.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+------------------------------------------
// in      | sink      | in_valid / in_stall  | func par term_index coefficient term_order
//         |           |                      | exponents max_order x_mm a_rad y_mm b_rad
// out     | source    | out_valid / out_stall| map_value overflow
// cfg     | sink      | cfg_valid / cfg_ready| cfg_index cfg_data
//
// A load request writes the table while the sequencer stays idle. An evaluate request scales
// x and y, then walks the terms: each term is read, and unless it is flagged or its order ends
// the walk, its power steps and the coefficient product run through the single shared 33x33
// multiplier, which the scaling also uses; the table is one RAM with one read port.
// Reset clears the sequencer, the term counts and the output valid; the term table is
// not cleared. in_stall is high while a request is being worked on; a finished result
// that finds the output register still held waits in the finish step, and in_stall
// stays high until it moves on.
module inverse_map_polynomial_eval_core import impe_pkg::*; #(
	parameter int MAX_TERMS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [1:0]         par,
	input  logic [7:0]         term_index,
	input  logic signed [31:0] coefficient,
	input  logic [3:0]         term_order,
	input  logic [16:0]        exponents,
	input  logic [3:0]         max_order,
	input  logic signed [31:0] x_mm,
	input  logic signed [31:0] a_rad,
	input  logic signed [31:0] y_mm,
	input  logic signed [31:0] b_rad,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] map_value,
	output logic               overflow,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data
);

	localparam int SW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int DEPTH = 4 << SW;
	localparam int AW    = $clog2(DEPTH);

	state_t state_q, state_d;

	logic [8:0]         cnt_cfg_q [4];
	logic [8:0]         cnt_q;
	logic [8:0]         i_q;
	logic [1:0]         par_q;
	logic [3:0]         max_q;
	logic signed [31:0] x_q, y_q;
	logic signed [31:0] coord_q [4];
	logic signed [31:0] coef_q, mono_q;
	logic [15:0]        exps_q;
	logic signed [65:0] prod_q;
	logic signed [63:0] acc_q;
	logic               ovf_q;
	logic               out_valid_q;
	logic signed [31:0] map_value_q;
	logic               overflow_q;

	logic               in_acc;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [8:0]         cnt_sel, cnt_clamp;
	logic [8:0]         i_nxt;
	logic signed [32:0] mul_a, mul_b;
	logic [31:0]        x_mag, y_mag;
	logic [22:0]        quot;
	logic [1:0]         csel;
	logic               any_exp;
	logic [15:0]        exps_dec;
	logic signed [63:0] prod_rnd;
	logic [3:0]         rd_ord;
	logic               out_load;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;

	// term load: drop slots past capacity
	assign ram_we    = in_acc && (func == FUNC_LOAD) && (32'(term_index) < MAX_TERMS);
	assign ram_waddr = AW'({par, SW'(term_index)});
	assign ram_wdata = {exponents, term_order, coefficient};
	assign ram_raddr = AW'({par_q, SW'(i_q)});

	impe_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// a count past capacity acts as the capacity
	assign cnt_sel   = cnt_cfg_q[par];
	assign cnt_clamp = (32'(cnt_sel) > MAX_TERMS) ? 9'(MAX_TERMS) : cnt_sel;
	assign i_nxt     = i_q + 9'd1;

	assign x_mag = x_q[31] ? 32'(-x_q) : 32'(x_q);
	assign y_mag = y_q[31] ? 32'(-y_q) : 32'(y_q);
	assign quot  = prod_q[DIV_SHIFT+22:DIV_SHIFT];

	assign prod_rnd = rnd_q16(prod_q);
	assign rd_ord   = ram_rdata[35:32];

	// pick the lowest coordinate with exponent left, and count it down
	always_comb begin
		any_exp  = 1'b1;
		csel     = 2'd0;
		exps_dec = exps_q;
		if (exps_q[3:0] != 4'd0) begin
			csel           = 2'd0;
			exps_dec[3:0]  = exps_q[3:0] - 4'd1;
		end else if (exps_q[7:4] != 4'd0) begin
			csel           = 2'd1;
			exps_dec[7:4]  = exps_q[7:4] - 4'd1;
		end else if (exps_q[11:8] != 4'd0) begin
			csel           = 2'd2;
			exps_dec[11:8] = exps_q[11:8] - 4'd1;
		end else if (exps_q[15:12] != 4'd0) begin
			csel           = 2'd3;
			exps_dec[15:12] = exps_q[15:12] - 4'd1;
		end else begin
			any_exp = 1'b0;
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = 33'(mono_q);
		mul_b = 33'(coord_q[csel]);
		case (state_q)
			S_XDIV: begin
				mul_a = $signed({1'b0, x_mag + HALF_MM});
				mul_b = DIV_MAGIC;
			end
			S_YDIV: begin
				mul_a = $signed({1'b0, y_mag + HALF_MM});
				mul_b = DIV_MAGIC;
			end
			S_POW: begin
				if (!any_exp) begin
					mul_a = 33'(coef_q);
					mul_b = 33'(mono_q);
				end
			end
			default: begin
				mul_a = 33'(mono_q);
			end
		endcase
	end

	assign out_load = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_acc && func == FUNC_EVAL) state_d = S_XDIV;
			S_XDIV:   state_d = S_XFIX;
			S_XFIX:   state_d = S_YDIV;
			S_YDIV:   state_d = S_YFIX;
			S_YFIX:   state_d = (cnt_q == 9'd0) ? S_DONE : S_RD;
			S_RD:     state_d = S_TERM;
			S_TERM: begin
				if (rd_ord > max_q) begin
					state_d = S_DONE;
				end else if (ram_rdata[52]) begin
					state_d = (i_nxt >= cnt_q) ? S_DONE : S_RD;
				end else begin
					state_d = S_POW;
				end
			end
			S_POW:    state_d = any_exp ? S_POWFIX : S_ACC;
			S_POWFIX: state_d = S_POW;
			S_ACC:    state_d = (i_nxt >= cnt_q) ? S_DONE : S_RD;
			S_DONE:   if (out_load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				cnt_cfg_q[k] <= 9'd0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cnt_cfg_q[cfg_index] <= cfg_data;
			end
			if (state_q == S_DONE && out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				if (in_acc && func == FUNC_EVAL) begin
					par_q      <= par;
					max_q      <= max_order;
					cnt_q      <= cnt_clamp;
					x_q        <= x_mm;
					y_q        <= y_mm;
					coord_q[3] <= b_rad;
					i_q        <= 9'd0;
					acc_q      <= 64'sd0;
					// negating the most negative angle saturates
					if (a_rad == 32'sh8000_0000) begin
						coord_q[1] <= 32'sh7FFF_FFFF;
						ovf_q      <= 1'b1;
					end else begin
						coord_q[1] <= -a_rad;
						ovf_q      <= 1'b0;
					end
				end
			end
			S_XFIX: begin
				// x' = round(-x / 1000), ties away from zero
				coord_q[0] <= (!x_q[31] && x_q != 32'sd0) ? -32'(quot) : 32'(quot);
			end
			S_YFIX: begin
				coord_q[2] <= y_q[31] ? -32'(quot) : 32'(quot);
			end
			S_TERM: begin
				coef_q <= ram_rdata[31:0];
				exps_q <= ram_rdata[51:36];
				mono_q <= Q_ONE;
				if (ram_rdata[52]) begin
					i_q <= i_nxt;
				end
			end
			S_POW: begin
				exps_q <= exps_dec;
			end
			S_POWFIX: begin
				mono_q <= sat32(prod_rnd);
				if (sat_hit(prod_rnd)) begin
					ovf_q <= 1'b1;
				end
			end
			S_ACC: begin
				acc_q <= acc_q + prod_rnd;
				i_q   <= i_nxt;
			end
			S_DONE: begin
				if (out_load) begin
					map_value_q <= sat32(acc_q);
					overflow_q  <= ovf_q || sat_hit(acc_q);
				end
			end
			default: begin
				exps_q <= exps_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign map_value = map_value_q;
	assign overflow  = overflow_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result appeared outside the finish step");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (i_q < cnt_q))
		else $error("term read past the loaded count");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE))
		else $error("table written during an evaluation");

endmodule

[tb/sv/impe_checker.sv]
`timescale 1ns / 1ps
module impe_checker import impe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               func,
	input  logic [1:0]         par,
	input  logic [7:0]         term_index,
	input  logic signed [31:0] coefficient,
	input  logic [3:0]         term_order,
	input  logic [16:0]        exponents,
	input  logic [3:0]         max_order,
	input  logic signed [31:0] x_mm,
	input  logic signed [31:0] a_rad,
	input  logic signed [31:0] y_mm,
	input  logic signed [31:0] b_rad,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] map_value,
	input  logic               overflow,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data,
	output int                 errors,
	output int                 pending
);

	localparam int TERMS = 256;

	typedef struct packed {
		logic signed [31:0] coef;
		logic [3:0]         order;
		logic [16:0]        exps;
	} term_t;

	typedef struct {
		logic signed [31:0] value;
		logic               ovf;
	} map_result_t;

	term_t       terms [4][TERMS];
	logic [8:0]  term_counts [4];
	map_result_t map_q [$];

	// round(p / 2^16), ties away from zero
	function automatic longint q16_round(longint p);
		longint m;
		m = (p < 0) ? -p : p;
		m = (m + 64'sd32768) >>> 16;
		return (p < 0) ? -m : m;
	endfunction

	// round(n / 1000), ties away from zero
	function automatic longint mm_to_m(longint n);
		longint m;
		m = (n < 0) ? -n : n;
		m = (m + 64'sd500) / 64'sd1000;
		return (n < 0) ? -m : m;
	endfunction

	function automatic longint clamp32(longint v, inout logic ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic map_result_t eval_map();
		map_result_t r;
		longint      coord [4];
		longint      acc;
		longint      mono;
		logic        ovf;
		int          cnt;
		int          k;
		term_t       t;
		ovf      = 1'b0;
		acc      = 0;
		coord[0] = mm_to_m(-longint'(x_mm));
		coord[1] = clamp32(-longint'(a_rad), ovf);
		coord[2] = mm_to_m(longint'(y_mm));
		coord[3] = longint'(b_rad);
		cnt      = (term_counts[par] > TERMS) ? TERMS : int'(term_counts[par]);
		for (int i = 0; i < cnt; i++) begin
			t = terms[par][i];
			if (t.order > max_order)
				break;
			// a flagged term adds nothing, but its order still ends the walk
			if (t.exps[16])
				continue;
			mono = 64'sd65536;
			for (int c = 0; c < 4; c++) begin
				k = int'(t.exps[4*c +: 4]);
				repeat (k) mono = clamp32(q16_round(mono * coord[c]), ovf);
			end
			acc += q16_round(longint'(t.coef) * mono);
		end
		acc     = clamp32(acc, ovf);
		r.value = acc[31:0];
		r.ovf   = ovf;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		map_result_t want;
		if (!arst_n) begin
			errors  <= 0;
			pending <= 0;
			for (int i = 0; i < 4; i++)
				term_counts[i] = '0;
			map_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (map_q.size() == 0) begin
					$display("%0t: unexpected result map_value=%h overflow=%b",
						$time, map_value, overflow);
					errors <= errors + 1;
				end else begin
					want = map_q.pop_front();
					if (map_value !== want.value || overflow !== want.ovf) begin
						$display("%0t: mismatch expected map_value=%h overflow=%b, got %h %b",
							$time, want.value, want.ovf, map_value, overflow);
						errors <= errors + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				term_counts[cfg_index] = cfg_data;
			if (in_valid && !in_stall) begin
				if (func == FUNC_EVAL)
					map_q.insert(map_q.size(), eval_map());
				else
					terms[par][term_index] = '{coefficient, term_order, exponents};
			end
			pending <= map_q.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top import impe_pkg::*;;

	localparam int WATCHDOG_LIMIT = 200000;
	localparam int LONG_HOLD      = 3000;

	// table codes; register i holds the term count of table i
	localparam logic [1:0] TBL_ATA = 2'd0;
	localparam logic [1:0] TBL_YTA = 2'd1;
	localparam logic [1:0] TBL_DTA = 2'd3;

	typedef struct {
		logic               func;
		logic [1:0]         par;
		logic [7:0]         term_index;
		logic signed [31:0] coefficient;
		logic [3:0]         term_order;
		logic [16:0]        exponents;
		logic [3:0]         max_order;
		logic signed [31:0] x_mm;
		logic signed [31:0] a_rad;
		logic signed [31:0] y_mm;
		logic signed [31:0] b_rad;
	} request_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               func = FUNC_LOAD;
	logic [1:0]         par = TBL_ATA;
	logic [7:0]         term_index = '0;
	logic signed [31:0] coefficient = '0;
	logic [3:0]         term_order = '0;
	logic [16:0]        exponents = '0;
	logic [3:0]         max_order = '0;
	logic signed [31:0] x_mm = '0;
	logic signed [31:0] a_rad = '0;
	logic signed [31:0] y_mm = '0;
	logic signed [31:0] b_rad = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] map_value;
	logic               overflow;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [8:0]         cfg_data = '0;

	int errors;
	int pending;
	int idle_cycles = 0;

	// shared knobs between the sender and the receiver
	bit burst     = 1'b0;
	bit hold_long = 1'b0;

	// slots written so far, and the length of the written run from slot 0
	bit written [4][256];
	int written_run [4] = '{0, 0, 0, 0};

	always #10 clk = ~clk;

	inverse_map_polynomial_eval_core DUT (.*);

	impe_checker checker_i (.*);

	// Stop on a hang: nothing moved on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("inverse_map_polynomial_eval_core regression: fail");
				$finish;
			end
		end
	end

	// Receiver: random hold-off before each result, one long hold on request.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = burst ? 0 : $urandom_range(0, 12);
			if (hold_long) begin
				hold_long = 1'b0;
				n = LONG_HOLD;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Drive one request and hold it until accepted; leave valid high when the
	// next request follows back to back.
	task automatic send(request_t r, bit last_in_run);
		int gap;
		in_valid    <= 1'b1;
		func        <= r.func;
		par         <= r.par;
		term_index  <= r.term_index;
		coefficient <= r.coefficient;
		term_order  <= r.term_order;
		exponents   <= r.exponents;
		max_order   <= r.max_order;
		x_mm        <= r.x_mm;
		a_rad       <= r.a_rad;
		y_mm        <= r.y_mm;
		b_rad       <= r.b_rad;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (r.func == FUNC_LOAD) begin
			written[r.par][r.term_index] = 1'b1;
			while (written_run[r.par] < 256 && written[r.par][written_run[r.par]])
				written_run[r.par]++;
		end
		gap = burst ? 0 : $urandom_range(0, 12);
		if (last_in_run || gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Wait until every result is in, then let any trailing load drain.
	task automatic wait_idle();
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_counts(logic [8:0] c0, logic [8:0] c1, logic [8:0] c2,
	                            logic [8:0] c3);
		logic [8:0] vals [4];
		vals = '{c0, c1, c2, c3};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return 32'($signed($urandom_range(0, 262143)) - 131072);
			2:       return 32'($signed($urandom_range(0, 8000000)) - 4000000);
			default: return 32'($signed($urandom_range(0, 131072)) - 65536);
		endcase
	endfunction

	// Random request; deep slots get light exponents to bound the walk time.
	function automatic request_t rand_request(bit is_eval, logic [1:0] tbl, logic [7:0] idx);
		request_t r;
		bit       heavy;
		r.func        = is_eval ? FUNC_EVAL : FUNC_LOAD;
		r.par         = tbl;
		r.term_index  = idx;
		r.coefficient = ($urandom_range(0, 1)) ? $urandom
		                : 32'($signed($urandom_range(0, 262143)) - 131072);
		r.term_order  = 4'($urandom_range(0, 15));
		heavy         = (idx < 16) && ($urandom_range(0, 3) == 0);
		for (int c = 0; c < 4; c++)
			r.exponents[4*c +: 4] = heavy ? 4'($urandom_range(0, 15))
			                        : 4'($urandom_range(0, 1));
		r.exponents[16] = ($urandom_range(0, 7) == 0);
		r.max_order   = 4'($urandom_range(0, 15));
		r.x_mm        = rand_coord();
		r.a_rad       = rand_coord();
		r.y_mm        = rand_coord();
		r.b_rad       = rand_coord();
		return r;
	endfunction

	function automatic logic [8:0] rand_count(int run);
		int lim;
		lim = (run > 16) ? 16 : run;
		case ($urandom_range(0, 5))
			0:       return 9'd0;
			1:       return 9'(lim);
			default: return 9'($urandom_range(0, lim));
		endcase
	endfunction

	initial begin
		request_t   r;
		logic [7:0] idx;
		logic [1:0] tbl;
		int         n_items;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: extreme terms into the angle table, and one term into table YTA.
		r = rand_request(1'b0, TBL_ATA, 8'd0);
		r.coefficient = 32'sh7FFF_FFFF; r.term_order = 4'd0; r.exponents = '0;
		send(r, 1'b0);
		r = rand_request(1'b0, TBL_ATA, 8'd1);
		r.coefficient = 32'sh8000_0000; r.term_order = 4'd1; r.exponents = 17'h00001;
		send(r, 1'b0);
		// flagged term: adds nothing, still ends the walk by order
		r = rand_request(1'b0, TBL_ATA, 8'd2);
		r.term_order = 4'd2; r.exponents = 17'h1FFFF;
		send(r, 1'b0);
		r = rand_request(1'b0, TBL_ATA, 8'd3);
		r.coefficient = 32'sh0001_0000; r.term_order = 4'd15; r.exponents = 17'h0FFFF;
		send(r, 1'b0);
		r = rand_request(1'b0, TBL_YTA, 8'd0);
		r.term_order = 4'd0; r.exponents = 17'h00100;
		send(r, 1'b1);
		wait_idle();
		write_counts(9'd4, 9'd0, 9'd0, 9'd0);

		for (int m = 0; m < 16; m++) begin
			r = rand_request(1'b1, TBL_ATA, 8'd0);
			r.max_order = 4'(m);
			case (m % 4)
				0: begin
					// saturating corners: most negative x and angle
					r.x_mm = 32'sh8000_0000; r.a_rad = 32'sh8000_0000;
					r.y_mm = 32'sh7FFF_FFFF; r.b_rad = 32'sh7FFF_FFFF;
				end
				1: begin
					r.x_mm = '0; r.a_rad = '0; r.y_mm = '0; r.b_rad = '0;
				end
				2: begin
					r.x_mm = 32'sh7FFF_FFFF; r.a_rad = 32'sh7FFF_FFFF;
					r.y_mm = 32'sh8000_0000; r.b_rad = 32'sh8000_0000;
				end
				default: begin
					// ties on the mm scaling
					r.x_mm = 32'sd500; r.y_mm = -32'sd1500; r.a_rad = 32'sh0001_0000;
				end
			endcase
			send(r, 1'b0);
		end
		// empty walk on a table with a zero count
		r = rand_request(1'b1, TBL_YTA, 8'd0);
		send(r, 1'b1);
		wait_idle();

		// Fill the delta table completely, back to back, with light terms past slot 15, then
		// walk it at the full count and at a count above capacity.
		burst = 1'b1;
		for (int s = 0; s < 256; s++) begin
			r = rand_request(1'b0, TBL_DTA, 8'(s));
			r.term_order = (s < 250) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
			send(r, s == 255);
		end
		burst = 1'b0;
		wait_idle();
		write_counts(9'd4, 9'd1, 9'd0, 9'd256);
		r = rand_request(1'b1, TBL_DTA, 8'd0);
		r.max_order = 4'd15;
		send(r, 1'b1);
		wait_idle();
		write_counts(9'd0, 9'd0, 9'd0, 9'd511);
		r = rand_request(1'b1, TBL_DTA, 8'd0);
		r.max_order = 4'd15;
		send(r, 1'b1);
		wait_idle();

		// Random phases: new counts each phase, mostly evaluations mixed with loads that
		// extend the written run.
		for (int ph = 0; ph < 4; ph++) begin
			write_counts(rand_count(written_run[0]), rand_count(written_run[1]),
			             rand_count(written_run[2]),
			             (ph == 3) ? 9'd256 : rand_count(written_run[3]));
			burst = (ph == 1);
			// one phase: long output hold while evaluations keep coming
			if (ph == 2)
				hold_long = 1'b1;
			n_items = 3;
			for (int it = 0; it < n_items; it++) begin
				tbl = 2'($urandom_range(0, 3));
				if ((ph == 2) || ($urandom_range(0, 9) < 6)) begin
					r = rand_request(1'b1, tbl, 8'($urandom));
				end else begin
					if ($urandom_range(0, 4) == 0)
						idx = 8'($urandom);
					else
						idx = 8'($urandom_range(0, (written_run[tbl] > 20) ? 20
						                        : written_run[tbl]));
					r = rand_request(1'b0, tbl, idx);
				end
				send(r, it == n_items - 1);
			end
			burst = 1'b0;
			// hold the sender until every result of the phase is back
			wait_idle();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("inverse_map_polynomial_eval_core regression: pass");
		else
			$display("inverse_map_polynomial_eval_core regression: fail");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/impe_pkg.sv
hw/rtl/impe_ram.sv
hw/rtl/inverse_map_polynomial_eval_core.sv
tb/sv/impe_checker.sv
tb/sv/tb_top.sv
